[hdl/aqz_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aqz_pkg
// Shared widths and constants for the air quality z-score scorer.
// ----------------------------------------------------------------------------
package aqz_pkg;

  localparam int unsigned GAS_W   = 24;
  localparam int unsigned HUM_W   = 17;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned Q_W     = 24;
  localparam int unsigned LOG_W   = 21;  // log2 in Q16: 5 integer bits, 16 fraction bits
  localparam int unsigned DIVN_W  = 48;  // dividend width of the shared divider
  localparam int unsigned DIVD_W  = 32;  // divisor width of the shared divider
  localparam int unsigned SSQ_W   = 48;
  localparam int unsigned SD_W    = 24;
  localparam int unsigned SCORE_W = 10;

  localparam logic [31:0]      LN2_Q32  = 32'd2977044472;
  localparam logic [Q_W-1:0]   Q_MAX    = 24'd8388607;
  localparam logic [SSQ_W-1:0] SSQ_MAX  = {SSQ_W{1'b1}};
  localparam logic [GAIN_W-1:0] GAIN_RST = 16'd2621;

endpackage

[hdl/aqz_log_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aqz_log_unit
// Iterative base-two logarithm in Q16, one squaring per fraction bit.
// ----------------------------------------------------------------------------
module aqz_log_unit
  import aqz_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [GAS_W-1:0] r,
  output logic             done,
  output logic [LOG_W-1:0] log2_q16
);

  logic        busy;
  logic [3:0]  iter;
  logic [4:0]  expo;
  logic [31:0] x;
  logic [15:0] frac;
  logic [4:0]  expo_next;
  logic [31:0] x_init;
  logic [63:0] sq;
  logic [31:0] y;

  // Index of the top set bit of the resistance.
  always_comb begin
    expo_next = '0;
    for (int i = 1; i < GAS_W; i++) begin
      if (r[i]) begin
        expo_next = 5'(i);
      end
    end
    x_init = 32'(r) << (5'd30 - expo_next);
  end

  assign sq = 64'(x) * 64'(x);
  assign y  = sq[61:30];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= '0;
        expo <= expo_next;
        x    <= x_init;
        frac <= '0;
      end else if (busy) begin
        if (y[31]) begin
          x    <= y >> 1;
          frac <= {frac[14:0], 1'b1};
        end else begin
          x    <= y;
          frac <= {frac[14:0], 1'b0};
        end
        iter <= iter + 4'd1;
        if (iter == 4'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign log2_q16 = {expo, frac};

endmodule

[hdl/aqz_div_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aqz_div_unit
// Shared unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module aqz_div_unit
  import aqz_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVN_W-1:0] dividend,
  input  logic [DIVD_W-1:0] divisor,
  output logic              done,
  output logic [DIVN_W-1:0] quot,
  output logic [DIVD_W-1:0] rem
);

  logic              busy;
  logic [5:0]        iter;
  logic [DIVD_W-1:0] den;
  logic [DIVD_W:0]   trial;

  assign trial = {rem, quot[DIVN_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= '0;
        quot <= dividend;
        rem  <= '0;
        den  <= divisor;
      end else if (busy) begin
        if (trial >= {1'b0, den}) begin
          rem  <= DIVD_W'(trial - {1'b0, den});
          quot <= {quot[DIVN_W-2:0], 1'b1};
        end else begin
          rem  <= trial[DIVD_W-1:0];
          quot <= {quot[DIVN_W-2:0], 1'b0};
        end
        iter <= iter + 6'd1;
        if (iter == 6'(DIVN_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[hdl/aqz_sqrt_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aqz_sqrt_unit
// Iterative integer square root of a 48-bit value, two bits per cycle.
// ----------------------------------------------------------------------------
module aqz_sqrt_unit
  import aqz_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SSQ_W-1:0] value,
  output logic             done,
  output logic [SD_W-1:0]  root
);

  logic             busy;
  logic [4:0]       iter;
  logic [SSQ_W-1:0] v;
  logic [SSQ_W-1:0] res;
  logic [SSQ_W-1:0] bitv;
  logic [SSQ_W:0]   trial;

  assign trial = {1'b0, res} + {1'b0, bitv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= '0;
        v    <= value;
        res  <= '0;
        bitv <= SSQ_W'(1) << (SSQ_W - 2);
      end else if (busy) begin
        if ({1'b0, v} >= trial) begin
          v   <= SSQ_W'({1'b0, v} - trial);
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        iter <= iter + 5'd1;
        if (iter == 5'(SD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root = res[SD_W-1:0];

endmodule

[hdl/air_quality_zscore_scorer_core.sv]
`timescale 1ns / 1ps
// From an accepted input beat to output tvalid an item passes a 16-step log,
// three 48-step passes of the shared divider, a 24-step square root and sequencing.
// A zero-ohm reading skips the log, and a zero square root skips the last division.
// One item is processed at a time: the next input beat is taken the cycle after
// the output beat. Reset (rst, synchronous, high) clears the statistics and score
// and restores the gain to GAIN_RST.
// ----------------------------------------------------------------------------
// air_quality_zscore_scorer_core
// Air quality scorer: ln(R) plus a humidity term, a Welford running mean and
// sum of squares, and a z-score mapped onto a clamped 10-bit scale.
// ----------------------------------------------------------------------------
module air_quality_zscore_scorer_core
  import aqz_pkg::*;
#(
  parameter int unsigned MAX_SCORE  = 1023,
  parameter int unsigned MID_SCORE  = 768,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,       // humidity_gain
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,    // gas_ohms[23:0], humidity_frac[40:24], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,    // score_out[9:0], quality_out[33:10],
                                       // mean_out[57:34], zero pad
  output logic [0:0]  m_axis_tuser     // score_valid
);

  // The highest score the output can carry and the saturated mid-point.
  localparam int unsigned UPPER   = (MAX_SCORE < 1023) ? MAX_SCORE : 1023;
  localparam int unsigned MID_SAT = (MID_SCORE > 1023) ? 1023 : MID_SCORE;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOG, ST_LN, ST_SUM, ST_COUNT, ST_MEAN, ST_DEV, ST_PROD,
    ST_ACC, ST_VAR, ST_SQRT, ST_SCORE, ST_OUT
  } state_t;

  state_t state;

  // Configuration and running statistics.
  logic [GAIN_W-1:0]     gain;
  logic [COUNT_BITS-1:0] count;
  logic signed [Q_W-1:0] mean;
  logic [SSQ_W-1:0]      ssq;
  logic [SCORE_W-1:0]    score;
  logic                  score_ok;

  // Per-item working registers.
  logic [GAS_W-1:0]      r_in;
  logic [HUM_W-1:0]      h_in;
  logic [LOG_W-1:0]      log2_val;
  logic [LOG_W-1:0]      ln_val;
  logic [22:0]           hum_term;
  logic [Q_W-1:0]        q;
  logic signed [25:0]    delta;
  logic signed [25:0]    dev;
  logic [49:0]           prod;

  // Shared unit handshakes and operands.
  logic                  log_start, log_done;
  logic [LOG_W-1:0]      log_res;
  logic                  div_start, div_done;
  logic [DIVN_W-1:0]     div_a, div_quot;
  logic [DIVD_W-1:0]     div_b, div_rem;
  logic                  sqrt_start, sqrt_done;
  logic [SD_W-1:0]       sqrt_res;

  // Combinational helpers for the current step.
  logic [52:0]           ln_prod;
  logic [32:0]           hum_prod;
  logic [Q_W-1:0]        q_sum;
  logic [COUNT_BITS-1:0] count_next;
  logic signed [25:0]    delta_next;
  logic [25:0]           delta_mag;
  logic signed [Q_W-1:0] mean_next;
  logic [25:0]           dev_mag;
  logic [SSQ_W:0]        ssq_sum;
  logic [33:0]           num_mag;
  logic [34:0]           t_mag;
  logic signed [36:0]    t_val;
  logic signed [36:0]    s_val;
  logic [SCORE_W-1:0]    score_next;

  aqz_log_unit u_log (
    .clk      (clk),
    .rst      (rst),
    .start    (log_start),
    .r        (r_in),
    .done     (log_done),
    .log2_q16 (log_res)
  );

  aqz_div_unit u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  aqz_sqrt_unit u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .value (div_quot),
    .done  (sqrt_done),
    .root  (sqrt_res)
  );

  always_comb begin
    // ln(R) = log2(R) * ln 2, rounded; humidity term rounded to Q16.
    ln_prod  = 53'(log2_val) * 53'(LN2_Q32) + 53'(64'd2147483648);
    hum_prod = 33'(gain) * 33'(h_in) + 33'd512;
    // Both terms together stay below 2^24, so the sum cannot wrap.
    q_sum    = Q_W'(ln_val) + Q_W'(hum_term);

    // The sample count saturates at its all-ones value.
    count_next = (count == {COUNT_BITS{1'b1}}) ? count : count + 1'b1;
    delta_next = $signed({2'b00, q}) - 26'(mean);
    delta_mag  = delta[25] ? 26'(-delta) : delta;

    // The mean step truncates toward zero, so the quotient takes delta's sign.
    mean_next  = delta[25] ? Q_W'(mean - $signed(div_quot[Q_W-1:0]))
                           : Q_W'(mean + $signed(div_quot[Q_W-1:0]));
    dev_mag    = dev[25] ? 26'(-dev) : dev;
    ssq_sum    = {1'b0, ssq} + (SSQ_W + 1)'(prod);

    // Score: floor division of 256*dev by sd, then offset and clamp.
    num_mag    = {dev_mag, 8'd0};
    t_mag      = 35'(div_quot[33:0]) + ((dev[25] && div_rem != '0) ? 35'd1 : 35'd0);
    t_val      = dev[25] ? -$signed({2'b00, t_mag}) : $signed({2'b00, t_mag});
    s_val      = t_val + 37'sd768;
    if (s_val < 0) begin
      score_next = '0;
    end else if (s_val > 37'(UPPER)) begin
      score_next = SCORE_W'(UPPER);
    end else begin
      score_next = s_val[SCORE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      gain       <= GAIN_RST;
      count      <= '0;
      mean       <= '0;
      ssq        <= '0;
      score      <= '0;
      score_ok   <= 1'b0;
      log_start  <= 1'b0;
      div_start  <= 1'b0;
      sqrt_start <= 1'b0;
    end else begin
      log_start  <= 1'b0;
      div_start  <= 1'b0;
      sqrt_start <= 1'b0;
      if (cfg_we) begin
        gain <= cfg_wdata;
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            r_in <= s_axis_tdata[23:0];
            h_in <= s_axis_tdata[40:24];
            // A reading below one ohm gives a quality of zero.
            if (s_axis_tdata[23:0] == '0) begin
              q     <= '0;
              state <= ST_COUNT;
            end else begin
              log_start <= 1'b1;
              state     <= ST_LOG;
            end
          end
        end
        ST_LOG: begin
          if (log_done) begin
            log2_val <= log_res;
            state    <= ST_LN;
          end
        end
        ST_LN: begin
          ln_val   <= ln_prod[52:32];
          hum_term <= hum_prod[32:10];
          state    <= ST_SUM;
        end
        ST_SUM: begin
          q     <= (q_sum > Q_MAX) ? Q_MAX : q_sum;
          state <= ST_COUNT;
        end
        ST_COUNT: begin
          count     <= count_next;
          delta     <= delta_next;
          div_b     <= DIVD_W'(count_next);
          state     <= ST_MEAN;
          div_start <= 1'b1;
          div_a     <= DIVN_W'(delta_next[25] ? 26'(-delta_next) : delta_next);
        end
        ST_MEAN: begin
          if (div_done) begin
            mean  <= mean_next;
            state <= ST_DEV;
          end
        end
        ST_DEV: begin
          dev   <= $signed({2'b00, q}) - 26'(mean);
          state <= ST_PROD;
        end
        ST_PROD: begin
          prod  <= delta_mag[24:0] * dev_mag[24:0];
          state <= ST_ACC;
        end
        ST_ACC: begin
          ssq   <= ssq_sum[SSQ_W] ? SSQ_MAX : ssq_sum[SSQ_W-1:0];
          div_a <= ssq_sum[SSQ_W] ? SSQ_MAX : ssq_sum[SSQ_W-1:0];
          div_b <= DIVD_W'(count - 1'b1);
          // From the second sample on a fresh score is formed.
          if (count >= COUNT_BITS'(2)) begin
            score_ok  <= 1'b1;
            div_start <= 1'b1;
            state     <= ST_VAR;
          end else begin
            score_ok <= 1'b0;
            state    <= ST_OUT;
          end
        end
        ST_VAR: begin
          if (div_done) begin
            sqrt_start <= 1'b1;
            state      <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (sqrt_done) begin
            if (sqrt_res == '0) begin
              score <= SCORE_W'(MID_SAT);
              state <= ST_OUT;
            end else begin
              div_a     <= DIVN_W'(num_mag);
              div_b     <= DIVD_W'(sqrt_res);
              div_start <= 1'b1;
              state     <= ST_SCORE;
            end
          end
        end
        ST_SCORE: begin
          if (div_done) begin
            score <= score_next;
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata  = {6'd0, mean, q, score};
  assign m_axis_tuser  = score_ok;

endmodule

[dv/aqz_scoreboard.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aqz_scoreboard
// Watches the input, output and register write of the scorer, computes the
// expected score, quality and mean for every accepted input beat and
// compares them with the output beats in order.
// ----------------------------------------------------------------------------
module aqz_scoreboard
  import aqz_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,
  input  logic [0:0]  m_axis_tuser,
  output int          fail_count,
  output int          pending,
  output int          scores_seen
);

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               valid;
    logic [Q_W-1:0]     quality;
    logic [Q_W-1:0]     mean;
  } score_rec_t;

  score_rec_t expected_scores[$];

  logic [GAIN_W-1:0]  gain;
  logic [31:0]        n_samples;
  longint             mean_q16;
  logic [SSQ_W-1:0]   ssq;
  logic [SCORE_W-1:0] held_score;

  // Natural log in Q16 by repeated squaring of the normalised mantissa.
  function automatic longint ln_q16(input logic [23:0] r);
    int unsigned e;
    logic [63:0] x;
    logic [63:0] frac;
    e = 0;
    frac = 0;
    while (e < 23 && (r >> (e + 1)) != 0) e++;
    x = 64'(r) << (30 - e);
    for (int i = 0; i < 16; i++) begin
      x = (x * x) >> 30;
      frac = frac << 1;
      if (x >= 64'h8000_0000) begin
        x = x >> 1;
        frac = frac | 1;
      end
    end
    return longint'(((((64'(e) << 16) | frac) * 64'(LN2_Q32)) + 64'h8000_0000) >> 32);
  endfunction

  function automatic logic [63:0] sqrt_floor(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 46;
    for (int i = 0; i < 24; i++) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic score_rec_t score_sample(input logic [23:0] r, input logic [16:0] h);
    score_rec_t rec;
    longint q, delta, dev, num, t, s, sd;
    logic [63:0] prod, var_q;
    q = 0;
    if (r >= 1) begin
      q = ln_q16(r) + longint'((64'(gain) * 64'(h) + 512) >> 10);
      if (q > 8388607) q = 8388607;
    end
    if (n_samples != 32'hFFFF_FFFF) n_samples++;
    delta = q - mean_q16;
    mean_q16 = mean_q16 + delta / longint'(n_samples);
    dev = q - mean_q16;
    prod = (delta >= 0) ? 64'(delta) * 64'(dev) : 64'(-delta) * 64'(-dev);
    if (prod > 64'(SSQ_MAX) - 64'(ssq)) ssq = SSQ_MAX;
    else ssq = ssq + prod[SSQ_W-1:0];
    rec.valid = (n_samples >= 2);
    if (rec.valid) begin
      var_q = 64'(ssq) / 64'(n_samples - 1);
      sd = longint'(sqrt_floor(var_q));
      if (sd == 0) begin
        held_score = (768 > 1023) ? 10'd1023 : 10'd768;
      end else begin
        num = dev * 256;
        if (num >= 0) t = num / sd;
        else t = -((-num + sd - 1) / sd);
        s = t + 768;
        if (s < 0) s = 0;
        if (s > 1023) s = 1023;
        held_score = s[9:0];
      end
    end
    rec.score = held_score;
    rec.quality = q[23:0];
    rec.mean = mean_q16[23:0];
    return rec;
  endfunction

  always @(posedge clk) begin
    score_rec_t got, want;
    if (rst) begin
      gain <= GAIN_RST;
      n_samples = 0;
      mean_q16 = 0;
      ssq = 0;
      held_score = 0;
      expected_scores.delete();
      fail_count <= 0;
      scores_seen <= 0;
    end else begin
      if (cfg_we) gain <= cfg_wdata;
      if (s_axis_tvalid && s_axis_tready)
        expected_scores.push_back(score_sample(s_axis_tdata[23:0], s_axis_tdata[40:24]));
      if (m_axis_tvalid && m_axis_tready) begin
        scores_seen <= scores_seen + 1;
        got.score = m_axis_tdata[9:0];
        got.quality = m_axis_tdata[33:10];
        got.mean = m_axis_tdata[57:34];
        got.valid = m_axis_tuser[0];
        if (expected_scores.size() == 0) begin
          if (fail_count < 10) $display("unexpected output beat %h", m_axis_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_scores.pop_front();
          if (got != want) begin
            if (fail_count < 10)
              $display("mismatch: want score %0d valid %0d q %h mean %h, got %0d %0d %h %h",
                       want.score, want.valid, want.quality, want.mean,
                       got.score, got.valid, got.quality, got.mean);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= expected_scores.size();
  end

endmodule

[dv/tb_air_quality_zscore_scorer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_air_quality_zscore_scorer_core
// Drives gas and humidity beats with random gaps and back-pressure across
// several gain settings; a separate scoreboard predicts and checks results.
// ----------------------------------------------------------------------------
module tb_air_quality_zscore_scorer_core;
  import aqz_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  int fail_count, pending, scores_seen;
  int src_idle_pct = 0;   // percentage of cycles in which the sender holds back
  int snk_idle_pct = 0;   // percentage of cycles in which the receiver stalls
  int quiet_cycles = 0;
  int beats_sent = 0;

  always #5 clk = ~clk;

  air_quality_zscore_scorer_core DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  aqz_scoreboard checker_i (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser), .fail_count(fail_count), .pending(pending),
    .scores_seen(scores_seen)
  );

  // The receiver stalls at random, changing only at the falling edge.
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // The watchdog counts cycles with no beat on either side and fails the run
  // when that count passes its limit.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("tb_air_quality_zscore_scorer_core failed");
      $finish;
    end
  end

  // One beat: optional random gap with tvalid low, then hold tvalid until it
  // is accepted. tvalid stays high afterwards so beats can follow back to back.
  task automatic send_reading(input logic [23:0] ohms, input logic [16:0] hum);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tdata <= {7'd0, hum, ohms};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    beats_sent++;
  endtask

  // Waits for every expected result, then the block's latency, before a write.
  task automatic drain_then_set_gain(input logic [15:0] g);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (250) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= g;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Resistances are drawn across all octaves so the log sees every exponent;
  // humidity is mostly realistic, sometimes the whole 17-bit range.
  task automatic send_random(input int count);
    logic [23:0] r;
    logic [16:0] h;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0: r = '0;
        1: r = 24'($urandom);
        default: r = 24'($urandom) >> $urandom_range(23);
      endcase
      h = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(102400));
      send_reading(r, h);
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Directed: held score before the second sample, zero resistance,
    // identical readings giving zero deviation, field extremes.
    send_reading(24'd1000, 17'd0);
    send_reading(24'd1000, 17'd0);
    send_reading(24'd1000, 17'd0);
    send_reading(24'd0, 17'd102400);
    send_reading(24'd1, 17'd0);
    send_reading(24'hFFFFFF, 17'h1FFFF);
    send_reading(24'd2, 17'd51200);
    send_reading(24'h800000, 17'd1);
    send_reading(24'd0, 17'd0);
    send_reading(24'hFFFFFF, 17'd0);
    // Sender pauses here until every expected result has come back.
    drain_then_set_gain(16'hFFFF);
    // Maximum gain and humidity push the quality into saturation.
    send_reading(24'hFFFFFF, 17'h1FFFF);
    send_reading(24'hFFFFFF, 17'h1FFFF);
    send_reading(24'd5, 17'd0);
    drain_then_set_gain(16'd0);
    send_reading(24'd3, 17'h1FFFF);
    send_reading(24'h555555, 17'h0AAAA);

    src_idle_pct = 6;
    snk_idle_pct = 79;
    send_random(450);
    drain_then_set_gain(16'($urandom));
    src_idle_pct = 79;
    snk_idle_pct = 6;
    send_random(450);
    drain_then_set_gain(GAIN_RST);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    send_random(530);

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (250) @(negedge clk);
    $display("Sent %0d readings over four gain settings, %0d scores checked.",
             beats_sent, scores_seen);
    if (fail_count == 0)
      $display("tb_air_quality_zscore_scorer_core passed");
    else
      $display("tb_air_quality_zscore_scorer_core failed");
    $finish;
  end

endmodule
